/* rtl/core/rmn_alu_pkg.sv */
// Shared types and constants for the rational mixed-number arithmetic unit.
// No dependencies.
package rmn_alu_pkg;

    // Operation codes carried on the mode input
    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_LT  = 3'd3;
    localparam logic [2:0] MODE_EQ  = 3'd4;

    localparam int unsigned WHOLE_BITS = 48;
    localparam int unsigned NUMER_BITS = 24;
    localparam int unsigned DENOM_BITS = 25;

endpackage

/* rtl/core/rational_mixed_number_alu_top.sv */
// Top level of the rational mixed-number arithmetic unit: sequencer, shared
// restoring divider (also used for the GCD) and the result register.
// Depends on rmn_alu_pkg.
//
// Usage
//   Input channel (i_valid/o_ready) takes one item: a mode and two signed
//   mixed numbers. Output channel (o_valid/i_ready) gives one result item per
//   input item: a reduced proper mixed number and the two compare flags.
//   The block works on one item at a time; o_ready is high only when idle
//   and no result waits.
//   Operands are loaded in S_IDLE and cross-multiplied in S_MUL1 to S_MUL3;
//   S_COMB then forms the sum, product or compare. The Euclidean GCD runs
//   on one shared bit-serial divider (W = 4*OPERAND_BITS, 48 by default),
//   at most about 1.5*W remainder steps but typically a handful;
//   two more divisions reduce the fraction and one makes it proper.
//   Compare and zero results skip the divider.
//   Reset (i_rst_n low, synchronous) drops any item in progress and any
//   waiting result. When the receiver stalls, the result holds on the
//   output ports until taken; no new item is accepted meanwhile.
module rational_mixed_number_alu_top #(
    parameter int OPERAND_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [2:0]                             i_mode,
    input  logic [OPERAND_BITS-1:0]                i_a_whole,
    input  logic [OPERAND_BITS-1:0]                i_a_numer,
    input  logic [OPERAND_BITS-1:0]                i_a_denom,
    input  logic                                   i_a_negative,
    input  logic [OPERAND_BITS-1:0]                i_b_whole,
    input  logic [OPERAND_BITS-1:0]                i_b_numer,
    input  logic [OPERAND_BITS-1:0]                i_b_denom,
    input  logic                                   i_b_negative,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [rmn_alu_pkg::WHOLE_BITS-1:0]     o_res_whole,
    output logic [rmn_alu_pkg::NUMER_BITS-1:0]     o_res_numer,
    output logic [rmn_alu_pkg::DENOM_BITS-1:0]     o_res_denom,
    output logic                                   o_res_negative,
    output logic                                   o_is_less,
    output logic                                   o_is_equal
);

    localparam int OB  = OPERAND_BITS;
    localparam int W   = 4 * OB;           // value width of products / sums
    localparam int CW  = $clog2(W + 1);
    localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD, S_RED_N, S_RED_D,
        S_PROPER, S_OUT
    } t_state;

    t_state         r_state;
    logic [2:0]     r_mode;
    logic [OB-1:0]  r_a_den, r_b_den;
    logic [2*OB:0]  r_a_mag, r_b_mag;   // whole*den + numer
    logic           r_a_neg, r_b_neg;
    logic [W-1:0]   r_x, r_y;            // cross products / product of magnitudes
    logic [W-1:0]   r_nm, r_den;          // fraction before reduction
    logic           r_nneg;
    logic [W-1:0]   r_g0, r_g1;           // Euclid pair
    // shared divider
    logic [W-1:0]   r_dvd, r_dvs, r_quo;
    logic [W:0]     r_rem;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    // result register
    logic           r_valid;
    logic [W-1:0]   r_res_whole;
    logic [W-1:0]   r_res_numer, r_res_denom;
    logic           r_res_neg, r_less, r_equal;

    logic [W:0]     w_trial;
    logic [W:0]     w_shift;
    logic [OB-1:0]  w_ad, w_bd;
    logic [W:0]     w_sum;
    logic           w_xge;

    assign o_ready = (r_state == S_IDLE) && !r_valid;
    assign o_valid = r_valid;
    assign o_res_whole    = rmn_alu_pkg::WHOLE_BITS'(r_res_whole);
    assign o_res_numer    = rmn_alu_pkg::NUMER_BITS'(r_res_numer);
    assign o_res_denom    = rmn_alu_pkg::DENOM_BITS'(r_res_denom);
    assign o_res_negative = r_res_neg;
    assign o_is_less      = r_less;
    assign o_is_equal     = r_equal;

    // denominator zero is taken as one
    assign w_ad = (i_a_denom[OB-1:0] == '0) ? OB'(1) : i_a_denom[OB-1:0];
    assign w_bd = (i_b_denom[OB-1:0] == '0) ? OB'(1) : i_b_denom[OB-1:0];

    // one restoring-division step
    assign w_shift = {r_rem[W-1:0], r_dvd[W-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};

    assign w_sum = {1'b0, r_x} + {1'b0, r_y};
    assign w_xge = (r_x >= r_y);

    // sequencer, datapath and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            // divider runs alongside the sequencer
            if (r_busy) begin
                r_dvd <= {r_dvd[W-2:0], 1'b0};
                if (!w_trial[W]) begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == LAST_BIT) r_busy <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_mode  <= i_mode;
                        r_a_den <= w_ad;
                        r_b_den <= w_bd;
                        r_a_mag <= (2*OB+1)'(i_a_whole[OB-1:0] * w_ad)
                                   + (2*OB+1)'(i_a_numer[OB-1:0]);
                        r_b_mag <= (2*OB+1)'(i_b_whole[OB-1:0] * w_bd)
                                   + (2*OB+1)'(i_b_numer[OB-1:0]);
                        r_a_neg <= i_a_negative;
                        r_b_neg <= i_b_negative;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_a_neg <= r_a_neg && (r_a_mag != '0);
                    r_b_neg <= r_b_neg && (r_b_mag != '0);
                    if (r_mode == rmn_alu_pkg::MODE_MUL)
                        r_x <= W'(r_a_mag * r_b_mag);
                    else
                        r_x <= W'(r_a_mag * r_b_den);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_y <= W'(r_b_mag * r_a_den);
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_den <= W'(r_a_den * r_b_den);
                    // subtract and compare negate b
                    if (r_mode == rmn_alu_pkg::MODE_SUB || r_mode == rmn_alu_pkg::MODE_LT
                        || r_mode == rmn_alu_pkg::MODE_EQ)
                        r_b_neg <= !r_b_neg && (r_b_mag != '0);
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    r_less  <= 1'b0;
                    r_equal <= 1'b0;
                    r_nm    <= '0;
                    r_nneg  <= 1'b0;
                    case (r_mode)
                        rmn_alu_pkg::MODE_ADD, rmn_alu_pkg::MODE_SUB,
                        rmn_alu_pkg::MODE_LT, rmn_alu_pkg::MODE_EQ: begin
                            logic [W-1:0] v_m;
                            logic         v_n;
                            if (r_a_neg == r_b_neg) begin
                                v_m = W'(w_sum);
                                v_n = r_a_neg;
                            end else if (w_xge) begin
                                v_m = r_x - r_y;
                                v_n = r_a_neg;
                            end else begin
                                v_m = r_y - r_x;
                                v_n = r_b_neg;
                            end
                            if (r_mode == rmn_alu_pkg::MODE_LT)
                                r_less <= v_n && (v_m != '0);
                            else if (r_mode == rmn_alu_pkg::MODE_EQ)
                                r_equal <= (v_m == '0);
                            else begin
                                r_nm   <= v_m;
                                r_nneg <= v_n && (v_m != '0);
                            end
                        end
                        rmn_alu_pkg::MODE_MUL: begin
                            r_nm   <= r_x;
                            r_nneg <= (r_a_neg != r_b_neg) && (r_x != '0);
                        end
                        default: ;
                    endcase
                    r_state <= S_GCD;
                    r_g0    <= '0;
                    r_g1    <= '0;
                end
                S_GCD: begin
                    if (r_nm == '0) begin
                        // zero result: whole 0, numerator 0, denominator 1
                        r_res_whole <= '0;
                        r_res_numer <= '0;
                        r_res_denom <= W'(1);
                        r_res_neg   <= 1'b0;
                        r_state     <= S_OUT;
                    end else if (r_g0 == '0 && r_g1 == '0) begin
                        r_g0 <= r_nm;
                        r_g1 <= r_den;
                    end else if (!r_busy && r_cnt == '0) begin
                        if (r_g1 == '0) begin
                            // r_g0 is the GCD: divide numerator by it
                            r_dvd <= r_nm; r_dvs <= r_g0; r_rem <= '0;
                            r_busy <= 1'b1;
                            r_state <= S_RED_N;
                        end else begin
                            r_dvd <= r_g0; r_dvs <= r_g1; r_rem <= '0;
                            r_busy <= 1'b1;
                        end
                    end else if (!r_busy) begin
                        r_g0  <= r_g1;
                        r_g1  <= W'(r_rem);
                        r_cnt <= '0;
                    end
                end
                S_RED_N: begin
                    if (!r_busy) begin
                        r_nm  <= r_quo;
                        r_dvd <= r_den; r_dvs <= r_g0; r_rem <= '0;
                        r_cnt <= '0;
                        r_busy <= 1'b1;
                        r_state <= S_RED_D;
                    end
                end
                S_RED_D: begin
                    if (!r_busy) begin
                        r_den <= r_quo;
                        r_dvd <= r_nm; r_dvs <= r_quo; r_rem <= '0;
                        r_cnt <= '0;
                        r_busy <= 1'b1;
                        r_state <= S_PROPER;
                    end
                end
                S_PROPER: begin
                    if (!r_busy) begin
                        r_res_whole <= r_quo;
                        r_res_numer <= W'(r_rem);
                        r_res_denom <= (r_rem == '0) ? W'(1) : r_den;
                        r_res_neg   <= r_nneg;
                        r_cnt       <= '0;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_nm == '0) begin
                        r_res_whole <= '0;
                        r_res_numer <= '0;
                        r_res_denom <= W'(1);
                        r_res_neg   <= 1'b0;
                    end
                    r_cnt   <= '0;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
